// File: hw/rtl/gbfr_pkg.sv
package gbfr_pkg;

  localparam int unsigned FrameBufferBytes = 128;
  localparam int unsigned LenLimit         = FrameBufferBytes - 8;
  localparam int unsigned CountW           = $clog2(LenLimit + 1);
  localparam int unsigned OutLenW          = 7;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [7:0] ClassAck   = 8'h05;
  localparam logic [7:0] ClassNav   = 8'h01;
  localparam logic [7:0] IdAckAck   = 8'h01;
  localparam logic [7:0] IdNavPvt   = 8'h07;

  localparam logic [1:0] HdrClass  = 2'd0;
  localparam logic [1:0] HdrId     = 2'd1;
  localparam logic [1:0] HdrLenLo  = 2'd2;
  localparam logic [1:0] HdrLenHi  = 2'd3;

  typedef enum logic [5:0] {
    PhSync1   = 6'b000001,
    PhSync2   = 6'b000010,
    PhHeader  = 6'b000100,
    PhPayload = 6'b001000,
    PhCka     = 6'b010000,
    PhCkb     = 6'b100000
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] arm_class;
    logic [7:0] arm_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         class_byte;
    logic [7:0]         msg_id;
    logic [OutLenW-1:0] payload_length;
    logic               accepted;
    logic               ack_resolved;
    logic               still_waiting;
  } out_item_t;

endpackage

// File: hw/rtl/gbfr_in_reg.sv
module gbfr_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gbfr_pkg::in_item_t in_item_i,
  input  logic               room_i,
  output logic               fire_o,
  output gbfr_pkg::in_item_t item_o
);
  import gbfr_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign fire_o     = valid_q && room_i;
  assign in_stall_o = valid_q && !room_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (fire_o ? 1'b0 : valid_q);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: hw/rtl/gbfr_deframer.sv
module gbfr_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  gbfr_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output gbfr_pkg::out_item_t res_o
);
  import gbfr_pkg::*;

  phase_e            phase_q, phase_d;
  logic [7:0]        class_q, class_d;
  logic [7:0]        id_q, id_d;
  logic [7:0]        len_lo_q, len_lo_d;
  logic [CountW-1:0] len_q, len_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        sum_a_q, sum_a_d;
  logic [7:0]        sum_b_q, sum_b_d;
  logic [7:0]        rcv_a_q, rcv_a_d;
  logic [7:0]        acked_class_q, acked_class_d;
  logic [7:0]        acked_id_q, acked_id_d;
  logic [7:0]        pend_class_q, pend_class_d;
  logic [7:0]        pend_id_q, pend_id_d;

  logic [7:0]           b;
  logic [15:0]          full_len;
  logic [CountW:0]      cnt_inc;
  logic [CountW+OutLenW-1:0] len_ext;
  logic                 verdict;
  logic                 resolved;
  logic                 res_valid;

  assign b        = item_i.rx_byte;
  assign full_len = {b, len_lo_q};
  assign cnt_inc  = {1'b0, count_q} + {{CountW{1'b0}}, 1'b1};
  assign len_ext  = {{OutLenW{1'b0}}, len_q};

  always_comb begin
    phase_d       = phase_q;
    class_d       = class_q;
    id_d          = id_q;
    len_lo_d      = len_lo_q;
    len_d         = len_q;
    count_d       = count_q;
    sum_a_d       = sum_a_q;
    sum_b_d       = sum_b_q;
    rcv_a_d       = rcv_a_q;
    acked_class_d = acked_class_q;
    acked_id_d    = acked_id_q;
    pend_class_d  = pend_class_q;
    pend_id_d     = pend_id_q;
    verdict       = 1'b0;
    resolved      = 1'b0;
    res_valid     = 1'b0;

    if (item_i.action) begin
      pend_class_d = item_i.arm_class;
      pend_id_d    = item_i.arm_id;
    end else begin
      case (phase_q)
        PhSync1: begin
          if (b == SyncFirst) begin
            phase_d = PhSync2;
          end
        end
        PhSync2: begin
          if (b == SyncSecond) begin
            phase_d       = PhHeader;
            count_d       = '0;
            sum_a_d       = '0;
            sum_b_d       = '0;
            acked_class_d = '0;
            acked_id_d    = '0;
          end else begin
            phase_d = PhSync1;
          end
        end
        PhHeader: begin
          sum_a_d = sum_a_q + b;
          sum_b_d = sum_b_q + sum_a_d;
          count_d = cnt_inc[CountW-1:0];
          case (count_q[1:0])
            HdrClass: class_d  = b;
            HdrId:    id_d     = b;
            HdrLenLo: len_lo_d = b;
            HdrLenHi: begin
              count_d = '0;
              len_d   = full_len[CountW-1:0];
              if (full_len >= 16'(LenLimit)) begin
                phase_d = PhSync1;
              end else if (full_len == 16'd0) begin
                phase_d = PhCka;
              end else begin
                phase_d = PhPayload;
              end
            end
            default: ;
          endcase
        end
        PhPayload: begin
          sum_a_d = sum_a_q + b;
          sum_b_d = sum_b_q + sum_a_d;
          if (count_q == '0) begin
            acked_class_d = b;
          end else if (count_q == CountW'(1)) begin
            acked_id_d = b;
          end
          count_d = cnt_inc[CountW-1:0];
          if (cnt_inc >= {1'b0, len_q}) begin
            phase_d = PhCka;
          end
        end
        PhCka: begin
          rcv_a_d = b;
          phase_d = PhCkb;
        end
        PhCkb: begin
          phase_d = PhSync1;
          if (rcv_a_q == sum_a_q && b == sum_b_q) begin
            res_valid = 1'b1;
            if (class_q == ClassAck) begin
              if (pend_class_q == ClassAck) begin
                verdict = 1'b1;
              end else if (acked_class_q != pend_class_q || acked_id_q != pend_id_q) begin
                verdict = 1'b1;
              end else begin
                pend_class_d = ClassAck;
                resolved     = 1'b1;
                verdict      = (id_q == IdAckAck);
              end
            end else if (class_q == ClassNav) begin
              verdict = (id_q == IdNavPvt);
            end
          end
        end
        default: phase_d = PhSync1;
      endcase
    end
  end

  assign res_valid_o          = fire_i && res_valid;
  assign res_o.class_byte     = class_q;
  assign res_o.msg_id         = id_q;
  assign res_o.payload_length = len_ext[OutLenW-1:0];
  assign res_o.accepted       = verdict;
  assign res_o.ack_resolved   = resolved;
  assign res_o.still_waiting  = (pend_class_d != ClassAck);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhSync1;
      class_q       <= '0;
      id_q          <= '0;
      len_lo_q      <= '0;
      len_q         <= '0;
      count_q       <= '0;
      sum_a_q       <= '0;
      sum_b_q       <= '0;
      rcv_a_q       <= '0;
      acked_class_q <= '0;
      acked_id_q    <= '0;
      pend_class_q  <= ClassAck;
      pend_id_q     <= '0;
    end else if (fire_i) begin
      phase_q       <= phase_d;
      class_q       <= class_d;
      id_q          <= id_d;
      len_lo_q      <= len_lo_d;
      len_q         <= len_d;
      count_q       <= count_d;
      sum_a_q       <= sum_a_d;
      sum_b_q       <= sum_b_d;
      rcv_a_q       <= rcv_a_d;
      acked_class_q <= acked_class_d;
      acked_id_q    <= acked_id_d;
      pend_class_q  <= pend_class_d;
      pend_id_q     <= pend_id_d;
    end
  end

endmodule

// File: hw/rtl/gbfr_out_reg.sv
module gbfr_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  gbfr_pkg::out_item_t item_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gbfr_pkg::out_item_t out_item_o
);
  import gbfr_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign room_o      = !valid_q || !out_stall_i;
  assign valid_d     = load_i ? 1'b1 : (out_stall_i ? valid_q : 1'b0);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

endmodule

// File: hw/rtl/gnss_binary_frame_receiver_top.sv
// Deframes sync/class/id/length/payload/Fletcher-8 binary GNSS frames, one byte or arm
// command per transfer, one transfer per clock unless stalled. Each item passes the
// input register, per-byte logic and result register; a frame result is loaded into the
// result register as its last checksum byte leaves the input register. Frames with a
// bad checksum or a length of 120 or more give no result. An arm transfer (action 1)
// sets the pending acknowledge class/id; arming with class 0x05 clears the wait.
module gnss_binary_frame_receiver_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gbfr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gbfr_pkg::out_item_t out_item_o
);
  import gbfr_pkg::*;

  logic      room;
  logic      fire;
  in_item_t  item;
  logic      res_valid;
  out_item_t res;

  gbfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .room_i     (room),
    .fire_o     (fire),
    .item_o     (item)
  );

  gbfr_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gbfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .item_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
